@@ rtl/core/sabd_pkg.sv @@
`default_nettype none

package sabd_pkg;

  // Depth of the queue between the byte classifier and the decoder
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Byte positions within a 16-byte block
  localparam logic [3:0] PosHeader = 4'd0;
  localparam logic [3:0] PosFlags  = 4'd1;
  localparam logic [3:0] PosData0  = 4'd2;
  localparam logic [3:0] PosLast   = 4'd15;

  // Largest filter index; larger header values are clamped to it
  localparam logic [3:0] FilterMax = 4'd4;

  // Saturation bounds of a sample
  localparam logic signed [20:0] SampleMax = 21'sd32767;
  localparam logic signed [20:0] SampleMin = -21'sd32768;

  // Prediction rounding term and shift
  localparam logic signed [25:0] PredRound = 26'sd32;
  localparam int unsigned        PredShift = 6;

  // What a queued byte is
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_FLAGS  = 2'd1,
    KIND_DATA   = 2'd2
  } item_kind_e;

  // One classified byte on its way to the decoder
  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data_byte;
    logic       restart;
    logic       last_byte;
  } item_t;

  // Coefficient on the newest history sample
  function automatic logic signed [7:0] coef_newest(input logic [2:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // Coefficient on the older history sample
  function automatic logic signed [7:0] coef_older(input logic [2:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sabd_front.sv @@
`default_nettype none

module sabd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              in_restart_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output sabd_pkg::item_t        push_item_o
);

  logic [3:0] pos_q, pos_d;
  logic       take;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign push_o     = take;

  // Classify the byte by its place in the block
  always_comb begin
    push_item_o.data_byte = in_byte_i;
    push_item_o.restart   = in_restart_i;
    push_item_o.last_byte = (pos_q == sabd_pkg::PosLast);
    if (pos_q == sabd_pkg::PosHeader) begin
      push_item_o.kind = sabd_pkg::KIND_HEADER;
    end else if (pos_q == sabd_pkg::PosFlags) begin
      push_item_o.kind = sabd_pkg::KIND_FLAGS;
    end else begin
      push_item_o.kind = sabd_pkg::KIND_DATA;
    end
  end

  // Byte position, wraps back to the header after the last data byte
  always_comb begin
    pos_d = pos_q;
    if (take) begin
      pos_d = pos_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= sabd_pkg::PosHeader;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sabd_queue.sv @@
`default_nettype none

module sabd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  sabd_pkg::item_t        push_item_i,
  output logic                   full_o,
  output logic                   valid_o,
  output sabd_pkg::item_t        item_o,
  input  wire logic              pop_i
);

  sabd_pkg::item_t mem_q [sabd_pkg::QueueDepth];

  logic [sabd_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [sabd_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [sabd_pkg::QueueCntW-1:0] count_q, count_d;
  logic                           do_push, do_pop;

  assign full_o  = (count_q == sabd_pkg::QueueCntW'(sabd_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == sabd_pkg::QueuePtrW'(sabd_pkg::QueueDepth - 1))
                 ? '0 : wr_ptr_q + sabd_pkg::QueuePtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == sabd_pkg::QueuePtrW'(sabd_pkg::QueueDepth - 1))
                 ? '0 : rd_ptr_q + sabd_pkg::QueuePtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + sabd_pkg::QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - sabd_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sabd_back.sv @@
`default_nettype none

module sabd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  sabd_pkg::item_t        q_item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [15:0]            out_sample_o,
  output logic [2:0]             out_flags_o,
  output logic                   out_pair_o,
  output logic                   out_last_o
);

  typedef enum logic [1:0] {
    PH_LOW  = 2'b01,
    PH_HIGH = 2'b10
  } phase_e;

  phase_e phase_q, phase_d;

  logic [3:0]          shift_q, shift_d;
  logic [2:0]          filter_q, filter_d;
  logic [2:0]          flags_q, flags_d;
  logic signed [15:0]  hist_new_q, hist_new_d;
  logic signed [15:0]  hist_old_q, hist_old_d;

  logic                out_valid_q, out_valid_d;
  logic [15:0]         out_sample_q;
  logic [2:0]          out_flags_q;
  logic                out_pair_q;
  logic                out_last_q;

  logic                out_free;
  logic                load;
  logic [3:0]          nib;
  logic [3:0]          hdr_filter;
  logic signed [15:0]  scaled;
  logic signed [23:0]  prod_new;
  logic signed [23:0]  prod_old;
  logic signed [25:0]  pred;
  logic signed [19:0]  pred_sh;
  logic signed [20:0]  sum;
  logic signed [15:0]  sat;

  assign out_free = !out_valid_q || out_ready_i;

  // Shared multiply-add: one sample per cycle while the output register is free
  always_comb begin
    nib      = (phase_q == PH_HIGH) ? q_item_i.data_byte[7:4] : q_item_i.data_byte[3:0];
    scaled   = $signed({nib, 12'h000}) >>> shift_q;
    prod_new = 24'(hist_new_q) * 24'(sabd_pkg::coef_newest(filter_q));
    prod_old = 24'(hist_old_q) * 24'(sabd_pkg::coef_older(filter_q));
    pred     = $signed({{2{prod_new[23]}}, prod_new})
             + $signed({{2{prod_old[23]}}, prod_old})
             + sabd_pkg::PredRound;
    pred_sh  = pred[25:sabd_pkg::PredShift];
    sum      = $signed({{5{scaled[15]}}, scaled}) + $signed({pred_sh[19], pred_sh});
    if (sum > sabd_pkg::SampleMax) begin
      sat = 16'sh7FFF;
    end else if (sum < sabd_pkg::SampleMin) begin
      sat = -16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  // Header filter nibble, clamped
  assign hdr_filter = (q_item_i.data_byte[7:4] > sabd_pkg::FilterMax)
                    ? sabd_pkg::FilterMax : q_item_i.data_byte[7:4];

  // Execute the head of the queue
  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    filter_d   = filter_q;
    flags_d    = flags_q;
    hist_new_d = hist_new_q;
    hist_old_d = hist_old_q;
    pop_o      = 1'b0;
    load       = 1'b0;
    if (q_valid_i) begin
      unique case (q_item_i.kind)
        sabd_pkg::KIND_HEADER: begin
          pop_o    = 1'b1;
          shift_d  = q_item_i.data_byte[3:0];
          filter_d = hdr_filter[2:0];
          if (q_item_i.restart) begin
            hist_new_d = '0;
            hist_old_d = '0;
          end
        end
        sabd_pkg::KIND_FLAGS: begin
          pop_o   = 1'b1;
          flags_d = q_item_i.data_byte[2:0];
        end
        sabd_pkg::KIND_DATA: begin
          if (out_free) begin
            load       = 1'b1;
            hist_new_d = sat;
            hist_old_d = hist_new_q;
            if (phase_q == PH_HIGH) begin
              pop_o   = 1'b1;
              phase_d = PH_LOW;
            end else begin
              phase_d = PH_HIGH;
            end
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LOW;
      shift_q     <= '0;
      filter_q    <= '0;
      flags_q     <= '0;
      hist_new_q  <= '0;
      hist_old_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      filter_q    <= filter_d;
      flags_q     <= flags_d;
      hist_new_q  <= hist_new_d;
      hist_old_q  <= hist_old_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_sample_q <= sat;
      out_flags_q  <= flags_q;
      out_pair_q   <= (phase_q == PH_HIGH);
      out_last_q   <= (phase_q == PH_HIGH) && q_item_i.last_byte;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_flags_o  = out_flags_q;
  assign out_pair_o   = out_pair_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

@@ rtl/core/sound_adpcm_block_decoder.sv @@
`default_nettype none

// ADPCM block decoder: takes 16-byte blocks one byte per beat (header byte with
// shift and filter, flag byte, then 14 data bytes) and returns two saturated
// 16-bit samples per data byte, low nibble first. Prediction history carries
// across blocks; tuser high on a header beat clears it. A classifier tracks the
// byte position and feeds a short queue; the decoder behind it pops a header or
// flag byte as it applies it and a data byte after its high nibble, one sample
// per cycle while the output register is free, through a single multiply-add
// whose result feeds the next sample's prediction. An output register holds a
// finished sample while the input side keeps filling the queue.
module sound_adpcm_block_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] restart_history
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [15:0] sample
  output logic [3:0]       m_axis_tuser_o,   // [2:0] blk_flags, [3] last_of_pair
  output logic             m_axis_tlast_o    // last_of_block
);

  logic            push;
  sabd_pkg::item_t push_item;
  logic            q_full;
  logic            q_valid;
  sabd_pkg::item_t q_item;
  logic            pop;
  logic [2:0]      out_flags;
  logic            out_pair;

  sabd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .in_restart_i (s_axis_tuser_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  sabd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (pop)
  );

  sabd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_sample_o (m_axis_tdata_o),
    .out_flags_o  (out_flags),
    .out_pair_o   (out_pair),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = {out_pair, out_flags};

endmodule

`default_nettype wire

@@ sim/tb_sound_adpcm_block_decoder.sv @@
module tb_sound_adpcm_block_decoder;

  localparam int CycleLimit = 400000;
  localparam int RandomBeats = 600;
  localparam int CalmFrom = 520;

  // One byte beat waiting to be sent
  typedef struct {
    logic [7:0] data;
    logic       restart;
    logic       hold;   // wait until all samples are out before sending
    logic       calm;   // no idling from here on
  } adpcm_beat_t;

  // One decoded sample as it should leave the block
  typedef struct {
    logic signed [15:0] sample;
    logic [2:0]         flags;
    logic               pair_end;
    logic               block_end;
  } pcm_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  byte_data = '0;
  logic        byte_restart = 1'b0;
  logic        pcm_valid;
  logic        pcm_ready = 1'b0;
  logic [15:0] pcm_data;
  logic [3:0]  pcm_user;
  logic        pcm_last;

  adpcm_beat_t byte_q[$];
  pcm_result_t pcm_expected_q[$];

  int unsigned pcm_due = 0;
  int unsigned pcm_seen = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  logic        calm_phase = 1'b0;
  logic [3:0]  gen_pos = '0;

  // Decoder state mirror
  logic [3:0]         dec_pos = '0;
  logic [3:0]         dec_shift = '0;
  logic [2:0]         dec_filter = '0;
  logic [2:0]         dec_flags = '0;
  logic signed [15:0] hist_new = '0;
  logic signed [15:0] hist_old = '0;
  int                 newest_tap [0:4] = '{0, 60, 115, 98, 122};
  int                 older_tap  [0:4] = '{0, 0, -52, -55, -60};

  always #10 clk_i = ~clk_i;

  sound_adpcm_block_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (byte_valid),
    .s_axis_tready_o (byte_ready),
    .s_axis_tdata_i  (byte_data),
    .s_axis_tuser_i  (byte_restart),
    .m_axis_tvalid_o (pcm_valid),
    .m_axis_tready_i (pcm_ready),
    .m_axis_tdata_o  (pcm_data),
    .m_axis_tuser_o  (pcm_user),
    .m_axis_tlast_o  (pcm_last)
  );

  // One nibble through shift, two-tap prediction and saturation
  task automatic decode_nibble(input logic [3:0] nib, output logic signed [15:0] pcm);
    int s;
    int pred;
    s = (int'($signed(nib)) * 4096) >>> dec_shift;
    pred = int'(hist_new) * newest_tap[dec_filter] + int'(hist_old) * older_tap[dec_filter] + 32;
    s = s + (pred >>> 6);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    hist_old = hist_new;
    hist_new = s[15:0];
    pcm = s[15:0];
  endtask

  // Accepted byte beat: update the mirror and queue the samples it yields
  task automatic decode_beat(input logic [7:0] b, input logic restart);
    pcm_result_t r;
    logic signed [15:0] pcm;
    case (dec_pos)
      sabd_pkg::PosHeader: begin
        if (restart) begin
          hist_new = '0;
          hist_old = '0;
        end
        dec_shift = b[3:0];
        dec_filter = (b[7:4] > sabd_pkg::FilterMax) ? 3'(sabd_pkg::FilterMax) : b[6:4];
        dec_pos = sabd_pkg::PosFlags;
      end
      sabd_pkg::PosFlags: begin
        dec_flags = b[2:0];
        dec_pos = sabd_pkg::PosData0;
      end
      default: begin
        decode_nibble(b[3:0], pcm);
        r.sample = pcm;
        r.flags = dec_flags;
        r.pair_end = 1'b0;
        r.block_end = 1'b0;
        pcm_expected_q.push_back(r);
        decode_nibble(b[7:4], pcm);
        r.sample = pcm;
        r.pair_end = 1'b1;
        r.block_end = (dec_pos == sabd_pkg::PosLast);
        pcm_expected_q.push_back(r);
        dec_pos = dec_pos + 4'd1;
        pcm_due <= pcm_due + 2;
      end
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic restart, input logic hold,
                            input logic calm);
    adpcm_beat_t beat;
    beat.data = b;
    beat.restart = restart;
    beat.hold = hold;
    beat.calm = calm;
    byte_q.push_back(beat);
    gen_pos = gen_pos + 4'd1;
  endtask

  // Byte driver
  always @(posedge clk_i) begin : drive_blk
    logic fire;
    logic nxt_valid;
    adpcm_beat_t beat;
    if (rst_ni) begin
      fire = byte_valid && byte_ready;
      if (fire) decode_beat(byte_data, byte_restart);
      nxt_valid = byte_valid;
      if (fire || !byte_valid) begin
        nxt_valid = 1'b0;
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
        end else if (byte_q.size() != 0) begin
          // a held beat waits until every sample so far has been taken
          if (!(byte_q[0].hold && (fire || pcm_seen != pcm_due))) begin
            beat = byte_q.pop_front();
            byte_data <= beat.data;
            byte_restart <= beat.restart;
            calm_phase <= beat.calm;
            nxt_valid = 1'b1;
            if (!beat.calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
          end
        end
      end
      byte_valid <= nxt_valid;
    end
  end

  // Sample monitor and receiver stalls
  always @(posedge clk_i) begin : watch_blk
    pcm_result_t want;
    logic nxt_ready;
    if (rst_ni) begin
      if (pcm_valid && pcm_ready) begin
        pcm_seen <= pcm_seen + 1;
        if (pcm_expected_q.size() == 0) begin
          $error("unexpected sample beat: sample %0d", $signed(pcm_data));
          n_errors++;
        end else begin
          want = pcm_expected_q.pop_front();
          if (pcm_data !== want.sample) begin
            $error("sample: expected %0d, actual %0d", want.sample, $signed(pcm_data));
            n_errors++;
          end
          if (pcm_user[2:0] !== want.flags) begin
            $error("blk_flags: expected %0d, actual %0d", want.flags, pcm_user[2:0]);
            n_errors++;
          end
          if (pcm_user[3] !== want.pair_end) begin
            $error("last_of_pair: expected %0d, actual %0d", want.pair_end, pcm_user[3]);
            n_errors++;
          end
          if (pcm_last !== want.block_end) begin
            $error("last_of_block: expected %0d, actual %0d", want.block_end, pcm_last);
            n_errors++;
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall = recv_stall - 1;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if (!calm_phase && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 16);
      end
      pcm_ready <= nxt_ready;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stim_blk
    logic [7:0] b;
    logic       restart;
    logic       hold;
    int         next_hold;
    logic [7:0] picks [0:5];
    picks = '{8'h77, 8'h88, 8'h7F, 8'hF7, 8'h08, 8'h80};

    // Directed: filter 4, shift 0, restart, flag byte with upper bits set,
    // positive and negative saturation, nibble extremes
    queue_byte(8'h40, 1'b1, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    queue_byte(8'h77, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h77, 1'b1, 1'b0, 1'b0);
    queue_byte(8'h77, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h88, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h88, 1'b1, 1'b0, 1'b0);
    queue_byte(8'h88, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    queue_byte(8'h0F, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hF0, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h08, 1'b1, 1'b0, 1'b0);
    queue_byte(8'h7F, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hF7, 1'b0, 1'b0, 1'b0);
    // Shift 15, filter above 4 clamped, history kept across the block
    queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h77, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h88, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h5A, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hA5, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h12, 1'b0, 1'b0, 1'b0);

    // Random blocks; a few headers wait for the output side to drain
    next_hold = 200;
    for (int i = 0; i < RandomBeats; i++) begin
      hold = 1'b0;
      if (gen_pos == sabd_pkg::PosHeader) begin
        b[3:0] = 4'($urandom_range(0, 15));
        b[7:4] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(5, 15))
                                              : 4'($urandom_range(0, 4));
        restart = ($urandom_range(0, 3) == 0);
        if (i >= next_hold) begin
          hold = 1'b1;
          next_hold = next_hold + 200;
        end
      end else begin
        b = ($urandom_range(0, 3) == 0) ? picks[$urandom_range(0, 5)] : 8'($urandom);
        restart = ($urandom_range(0, 7) == 0);
      end
      queue_byte(b, restart, hold, i >= CalmFrom);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || byte_valid || pcm_seen != pcm_due) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (pcm_expected_q.size() != 0) begin
      $error("%0d expected samples never arrived", pcm_expected_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sabd_pkg.sv
rtl/core/sabd_front.sv
rtl/core/sabd_queue.sv
rtl/core/sabd_back.sv
rtl/core/sound_adpcm_block_decoder.sv
sim/tb_sound_adpcm_block_decoder.sv
